// ===== hdl/iosr_pkg.sv =====
// iosr_pkg: types, codes and constants for the in-order segment release block.
// No dependencies; imported by every module of the block.
`default_nettype none

package iosr_pkg;

    localparam int IDX_W      = 16;
    localparam int WINDOW_DEF = 64;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [IDX_W-1:0] START_INDEX_RST = 16'd1;

    // register number, taken from paddr[2] (word address)
    localparam logic REG_START_INDEX = 1'b0;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_HELD     = 2'd1,
        ST_STALE    = 2'd2,
        ST_BEYOND   = 2'd3
    } status_t;

    typedef enum logic {
        ALU_SUB = 1'b0,
        ALU_INC = 1'b1
    } alu_op_t;

    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_CLASSIFY = 2'd1,
        S_REPORT   = 2'd2,
        S_RELEASE  = 2'd3
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        status_t          status;
        logic             last;
    } result_t;

    typedef struct packed {
        logic idle;
        logic held_lsb;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== hdl/in_order_segment_release_top.sv =====
// In-order segment release: input word accepted in idle, classified in the next cycle;
// the first result word is registered once the output slot is free (out_ready may stall).
// Per item: a single result word, or n words for n released indices (n <= WINDOW);
// the release loop runs one shared adder step per result word.
// Reset: expected index 1, held map clear, start_index 1, no result pending.
`default_nettype none

module in_order_segment_release_top
    import iosr_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [IDX_W-1:0]   segment_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [IDX_W-1:0]   released_index,
    output logic [1:0]         status,
    output logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [IDX_W-1:0] start_index_reg;
    logic             cfg_load;
    logic             emit;
    logic             out_free;
    result_t          result;
    ctrl_status_t     ctrl_status;

    logic             out_valid_reg;
    result_t          out_reg;

    assign pready   = 1'b1;
    assign cfg_load = psel && penable && pwrite && pready && (paddr[2] == REG_START_INDEX);
    assign prdata   = (paddr[2] == REG_START_INDEX) ?
                      {{(PDATA_W-IDX_W){1'b0}}, start_index_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_index_reg <= START_INDEX_RST;
        end
        else if (cfg_load)
        begin
            start_index_reg <= pwdata[IDX_W-1:0];
        end
    end

    iosr_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .segment_index (segment_index),
        .out_free      (out_free),
        .emit          (emit),
        .result        (result),
        .cfg_load      (cfg_load),
        .cfg_value     (pwdata[IDX_W-1:0]),
        .ctrl_status   (ctrl_status)
    );

    // output register: slot free when empty or being taken this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign released_index = out_reg.idx;
    assign status         = out_reg.status;
    assign last           = out_reg.last;

`ifndef SYNTHESIS
    // one word at a time: no new input straight after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while previous word in progress");

    // anything other than a release is the sole result of its input
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_reg.status != ST_RELEASED)) |-> out_reg.last)
        else $error("non-release result without last");

    // an expected index that is held must have been released before going idle
    a_idle_no_head: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_status.idle |-> !ctrl_status.held_lsb)
        else $error("expected index held while idle");

    // a release with more to follow keeps the sequencer busy
    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (result.status == ST_RELEASED) && !result.last) |=> !in_ready)
        else $error("input ready in the middle of a release run");
`endif

endmodule

`default_nettype wire

// ===== hdl/iosr_alu.sv =====
// iosr_alu: shared 16-bit adder, used for the window offset and the index increment.
// Depends on iosr_pkg.
`default_nettype none

module iosr_alu
    import iosr_pkg::*;
(
    input  alu_op_t          op,
    input  logic [IDX_W-1:0] a,
    input  logic [IDX_W-1:0] b,
    output logic [IDX_W-1:0] res
);

    logic [IDX_W-1:0] b_mod;
    logic             cin;

    always_comb
    begin
        case (op)
            ALU_SUB:
            begin
                b_mod = ~b;
                cin   = 1'b1;
            end
            ALU_INC:
            begin
                b_mod = b;
                cin   = 1'b0;
            end
            default:
            begin
                b_mod = b;
                cin   = 1'b0;
            end
        endcase
    end

    // wraps modulo 2^16
    assign res = a + b_mod + IDX_W'(cin);

endmodule

`default_nettype wire

// ===== hdl/iosr_ctrl.sv =====
// iosr_ctrl: sequencer holding the expected index and held map, driving the shared adder.
// Depends on iosr_pkg and iosr_alu.
`default_nettype none

module iosr_ctrl
    import iosr_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IDX_W-1:0] segment_index,
    input  logic             out_free,
    output logic             emit,
    output result_t          result,
    input  logic             cfg_load,
    input  logic [IDX_W-1:0] cfg_value,
    output ctrl_status_t     ctrl_status
);

    localparam int OFF_W = $clog2(WINDOW);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  next_exp_reg, next_exp_next;
    logic [WINDOW-1:0] held_reg, held_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    status_t           stat_reg, stat_next;

    alu_op_t           alu_op;
    logic [IDX_W-1:0]  alu_a;
    logic [IDX_W-1:0]  alu_b;
    logic [IDX_W-1:0]  alu_res;

    iosr_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            next_exp_reg <= START_INDEX_RST;
            held_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            next_exp_reg <= next_exp_next;
            held_reg     <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        stat_reg <= stat_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        next_exp_next = next_exp_reg;
        held_next     = held_reg;
        idx_next      = idx_reg;
        stat_next     = stat_reg;
        in_ready      = 1'b0;
        emit          = 1'b0;
        result        = '{idx: idx_reg, status: stat_reg, last: 1'b1};
        alu_op        = ALU_SUB;
        alu_a         = idx_reg;
        alu_b         = next_exp_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (cfg_load)
                begin
                    next_exp_next = cfg_value;
                    held_next     = '0;
                end
                if (in_valid)
                begin
                    idx_next   = segment_index;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                // alu_res is the offset from the expected index
                state_next = S_REPORT;
                if (alu_res[IDX_W-1])
                begin
                    stat_next = ST_STALE;
                end
                else if (alu_res >= IDX_W'(WINDOW))
                begin
                    stat_next = ST_BEYOND;
                end
                else if (held_reg[alu_res[OFF_W-1:0]])
                begin
                    stat_next = ST_STALE;
                end
                else
                begin
                    held_next = held_reg | (WINDOW'(1) << alu_res[OFF_W-1:0]);
                    stat_next = ST_HELD;
                    if (held_next[0])
                    begin
                        state_next = S_RELEASE;
                    end
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RELEASE:
            begin
                alu_op = ALU_INC;
                alu_a  = next_exp_reg;
                alu_b  = IDX_W'(1);
                result = '{idx: next_exp_reg, status: ST_RELEASED, last: !held_reg[1]};
                if (out_free)
                begin
                    emit          = 1'b1;
                    next_exp_next = alu_res;
                    held_next     = held_reg >> 1;
                    if (!held_reg[1])
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ctrl_status = '{idle: (state_reg == S_IDLE), held_lsb: held_reg[0]};

endmodule

`default_nettype wire

// ===== test/iosr_release_checker.sv =====
`timescale 1ns / 1ps
// iosr_release_checker: watches the segment, result and APB channels, predicts the result
// words of every accepted segment word and compares them in order. Needs iosr_pkg.
module iosr_release_checker
    import iosr_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [IDX_W-1:0]   segment_index,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [IDX_W-1:0]   released_index,
    input  logic [1:0]         status,
    input  logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending
);

    logic [IDX_W-1:0] start_copy;
    logic [IDX_W-1:0] next_idx;
    logic [63:0]      held;
    result_t          release_q[$];

    function automatic void queue_word(input logic [IDX_W-1:0] idx, input status_t st,
                                       input logic lst);
        result_t w;
        w.idx    = idx;
        w.status = st;
        w.last   = lst;
        release_q.push_back(w);
    endfunction

    // Works out every result word one segment word causes and moves the window on.
    function automatic void predict_segment(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] ofs;
        logic [63:0]      rest;
        int               n;
        ofs = idx - next_idx;
        n   = 0;
        if (ofs[IDX_W-1])
            queue_word(idx, ST_STALE, 1'b1);
        else if (ofs >= WINDOW)
            queue_word(idx, ST_BEYOND, 1'b1);
        else if (held[ofs[5:0]])
            queue_word(idx, ST_STALE, 1'b1);
        else
        begin
            held[ofs[5:0]] = 1'b1;
            if (!held[0])
                queue_word(idx, ST_HELD, 1'b1);
            else
            begin
                while (held[0] && n < WINDOW)
                begin
                    rest = held >> 1;
                    // last word once the run of held bits ends or a full window has gone
                    queue_word(next_idx, ST_RELEASED, !rest[0] || (n + 1 >= WINDOW));
                    held     = rest;
                    next_idx = next_idx + 1'b1;
                    n++;
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t w;
        if (!rst_n)
        begin
            start_copy = 16'd1;
            next_idx   = 16'd1;
            held       = '0;
            errors     = 0;
            release_q.delete();
        end
        else
        begin
            if (psel && penable && pready && paddr[2] == REG_START_INDEX)
            begin
                if (pwrite)
                begin
                    start_copy = pwdata[IDX_W-1:0];
                    next_idx   = pwdata[IDX_W-1:0];
                    held       = '0;
                end
                else if (prdata[IDX_W-1:0] !== start_copy)
                begin
                    errors++;
                    $display("%0t: start_index read: expected %h, got %h",
                             $time, start_copy, prdata[IDX_W-1:0]);
                end
            end
            if (out_valid && out_ready)
            begin
                if (release_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with none expected: idx=%h status=%0d last=%0d",
                             $time, released_index, status, last);
                end
                else
                begin
                    w = release_q.pop_front();
                    if (released_index !== w.idx || status !== w.status || last !== w.last)
                    begin
                        errors++;
                        $display({"%0t: mismatch: expected idx=%h status=%0d last=%0d, ",
                                  "got idx=%h status=%0d last=%0d"},
                                 $time, w.idx, w.status, w.last,
                                 released_index, status, last);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_segment(segment_index);
        end
        pending = release_q.size();
    end

endmodule

// ===== test/tb_in_order_segment_release_top.sv =====
`timescale 1ns / 1ps
// tb_in_order_segment_release_top: drives segment words, APB writes and result back-pressure
// into in_order_segment_release_top; iosr_release_checker judges. Needs iosr_pkg and the RTL.
module tb_in_order_segment_release_top;
    import iosr_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 30;
    localparam logic [PADDR_W-1:0] START_ADDR = {REG_START_INDEX, 2'b00};

    typedef enum int { RX_FREE, RX_RANDOM, RX_PATTERN, RX_SPARSE } rx_mode_t;
    typedef enum int { NZ_DUP, NZ_BEYOND, NZ_BEHIND, NZ_RANDOM } noise_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [IDX_W-1:0]   segment_index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [IDX_W-1:0]   released_index;
    logic [1:0]         status;
    logic               last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 errors;
    int                 pending;

    bit        hold_req = 1'b0;
    bit        hold_served = 1'b0;
    int        hold_cnt = 0;
    rx_mode_t  rx_mode = RX_FREE;
    int        rx_left = 0;
    logic [7:0] rx_pat = 8'hA5;
    int        burst_left = 0;
    bit        gaps_on = 1'b1;
    int        sent = 0;

    in_order_segment_release_top dut (.*);

    iosr_release_checker #(.WINDOW(WINDOW_DEF)) u_checker (.*);

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result back-pressure: one long hold-off on request, otherwise changing stall modes.
    always @(negedge clk)
    begin
        if (hold_req && !hold_served)
        begin
            hold_served <= 1'b1;
            hold_cnt    <= LONG_HOLD;
            out_ready   <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(4, 60);
                rx_pat  <= 8'($urandom()) | 8'h01;
            end
            else
            begin
                rx_left <= rx_left - 1;
                rx_pat  <= {rx_pat[0], rx_pat[7:1]};
            end
            case (rx_mode)
                RX_FREE:    out_ready <= 1'b1;
                RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: out_ready <= rx_pat[0];
                default:    out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic offer_word(input logic [IDX_W-1:0] v);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 24)
                                                     : $urandom_range(1, 4);
            burst_left = $urandom_range(1, 16);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid      <= 1'b1;
        segment_index <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [IDX_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= START_ADDR;
        pwdata  <= {{(PDATA_W-IDX_W){1'b0}}, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_start(input logic [IDX_W-1:0] v);
        drain_results();
        apb_access(1'b1, v);
        apb_access(1'b0, v);
    endtask

    // Up to one window's worth (n) of consecutive indices from base, shuffled, with some noise mixed in.
    task automatic run_block(input logic [IDX_W-1:0] base, input int n, input bit base_last);
        int order[WINDOW_DEF];
        int k;
        int j;
        int tmp;
        for (k = 0; k < n; k++)
            order[k] = k;
        for (k = n - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        if (base_last)
        begin
            // expected index last, so the whole block goes out on one word
            for (k = 0; k < n; k++)
                if (order[k] == 0)
                begin
                    order[k]     = order[n - 1];
                    order[n - 1] = 0;
                end
        end
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 14)
            begin
                case (noise_t'($urandom_range(0, 3)))
                    NZ_DUP:    offer_word(k > 0 ? IDX_W'(base + order[$urandom_range(0, k - 1)])
                                                : IDX_W'(base - 1));
                    NZ_BEYOND: offer_word(IDX_W'(base + 128 + $urandom_range(0, 32000)));
                    NZ_BEHIND: offer_word(IDX_W'(base - 1 - $urandom_range(0, 32000)));
                    default:   offer_word(IDX_W'($urandom_range(0, 65535)));
                endcase
            end
            offer_word(IDX_W'(base + order[k]));
        end
    endtask

    initial
    begin
        logic [IDX_W-1:0] base;
        int p;
        int n;
        int goal;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // expected index starts at 1 out of reset
        offer_word(16'd1);      // straight release
        offer_word(16'd4);      // held
        offer_word(16'd3);      // held
        offer_word(16'd4);      // duplicate
        offer_word(16'd0);      // already passed
        offer_word(16'd2);      // releases 2..4
        offer_word(16'd68);     // top of window, held
        offer_word(16'd69);     // one past the window
        offer_word(16'd32772);  // furthest beyond
        offer_word(16'd32773);  // nearest counted as passed
        offer_word(16'hFFFF);
        offer_word(16'd5);

        // release run across the wrap
        load_start(16'hFFFE);
        offer_word(16'h0000);
        offer_word(16'hFFFF);
        offer_word(16'hFFFE);

        load_start(16'hFFFF);
        offer_word(16'hFFFF);
        offer_word(16'hFFFE);

        load_start(16'h0000);
        offer_word(16'h0000);
        offer_word(16'hFFFF);
        offer_word(16'h8000);
        offer_word(16'h8001);

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       base = 16'h0000;
                1:       base = 16'hFFFF;
                2:       base = 16'hFFD0;
                3:       base = 16'h7FF0;
                default: base = IDX_W'($urandom_range(0, 65535));
            endcase
            load_start(base);
            gaps_on = (p != 5);
            if (p == 3)
                hold_req = 1'b1;
            goal = sent + PHASE_ITEMS;
            while (sent < goal)
            begin
                case ($urandom_range(0, 9))
                    0:       n = WINDOW_DEF;
                    1, 2:    n = $urandom_range(13, WINDOW_DEF);
                    default: n = $urandom_range(1, 12);
                endcase
                run_block(base, n, ($urandom_range(0, 2) == 0) || (n == WINDOW_DEF));
                base = base + IDX_W'(n);
            end
        end

        drain_results();
        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
